// File: hdl/tlph_pkg.sv
// Shared types, codes, widths and helper functions for the two-locus pair histogram.
// No dependencies; used by tlph_hist and two_locus_pair_histogram_core.
package tlph_pkg;

    localparam int MAX_SAMPLES_DEF = 64;
    localparam int MAX_SITES_DEF   = 1024;

    localparam int SITE_W       = 64;
    localparam int OP_W         = 2;
    localparam int ROWCOL_W     = 6;
    localparam int CELL_W       = 19;
    localparam int STATUS_W     = 2;
    localparam int REL_W        = 2;
    localparam int SCOUNT_W     = 7;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int POP_FULL_W   = 7;

    localparam logic [SCOUNT_W-1:0] SAMPLE_COUNT_RESET = 7'd64;
    localparam logic [CELL_W-1:0]   CELL_MAX           = '1;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_REJECT = 2'd2
    } t_status;

    typedef enum logic [REL_W-1:0] {
        REL_ANY      = 2'd0,
        REL_NESTED   = 2'd1,
        REL_DISJOINT = 2'd2,
        REL_NONE     = 2'd3
    } t_relation;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RELATION = 2'd0,
        CFG_SAMPLES  = 2'd1
    } t_cfg_index;

    typedef struct packed {
        logic req;
        logic bump;
        logic clear;
    } t_hist_ctrl;

    function automatic logic [POP_FULL_W-1:0] popcount(input logic [SITE_W-1:0] v);
        logic [POP_FULL_W-1:0] s [SITE_W];
        for (int i = 0; i < SITE_W; i++) begin
            s[i] = POP_FULL_W'(v[i]);
        end
        // pairwise adder tree
        for (int w = SITE_W >> 1; w >= 1; w = w >> 1) begin
            for (int i = 0; i < w; i++) begin
                s[i] = s[2*i] + s[2*i+1];
            end
        end
        return s[0];
    endfunction

endpackage

// File: hdl/tlph_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Read-first on a same-address collision. No dependencies.
module tlph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hdl/tlph_hist.sv
// Pair histogram store: clearing sweep, saturating read-modify-write with forwarding, cell read.
// Depends on tlph_pkg and tlph_ram.
module tlph_hist #(
    parameter int MAX_SAMPLES = tlph_pkg::MAX_SAMPLES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tlph_pkg::t_hist_ctrl            i_ctrl,
    input  logic [$clog2(MAX_SAMPLES)-1:0]  i_row,
    input  logic [$clog2(MAX_SAMPLES)-1:0]  i_col,
    output logic                            o_busy,
    output logic [tlph_pkg::CELL_W-1:0]     o_rd_data
);

    localparam int HIST_DIM   = MAX_SAMPLES - 1;
    localparam int HIST_DEPTH = HIST_DIM * HIST_DIM;
    localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int CELL_W     = tlph_pkg::CELL_W;
    localparam logic [HIST_AW-1:0] DIM_C  = HIST_AW'(HIST_DIM);
    localparam logic [HIST_AW-1:0] LAST_C = HIST_AW'(HIST_DEPTH - 1);

    logic [HIST_AW-1:0] idx;
    logic [HIST_AW-1:0] row_m1;
    logic [HIST_AW-1:0] col_m1;

    logic               r_clr_busy;
    logic [HIST_AW-1:0] r_clr_addr;
    logic               r_b_valid;
    logic [HIST_AW-1:0] r_b_addr;
    logic               r_fw_valid;
    logic [HIST_AW-1:0] r_fw_addr;
    logic [CELL_W-1:0]  r_fw_data;

    logic [CELL_W-1:0]  ram_q;
    logic [CELL_W-1:0]  old_val;
    logic [CELL_W-1:0]  new_val;
    logic               wr_en;
    logic [HIST_AW-1:0] wr_addr;
    logic [CELL_W-1:0]  wr_data;

    assign row_m1 = HIST_AW'(i_row) - HIST_AW'(1);
    assign col_m1 = HIST_AW'(i_col) - HIST_AW'(1);
    assign idx    = row_m1 * DIM_C + col_m1;

    assign old_val = (r_fw_valid && (r_fw_addr == r_b_addr)) ? r_fw_data : ram_q;
    assign new_val = (old_val == tlph_pkg::CELL_MAX) ? old_val : old_val + CELL_W'(1);

    assign wr_en   = r_clr_busy | r_b_valid;
    assign wr_addr = r_clr_busy ? r_clr_addr : r_b_addr;
    assign wr_data = r_clr_busy ? '0 : new_val;

    tlph_ram #(
        .WIDTH (CELL_W),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_ctrl.req),
        .i_rd_addr (idx),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_b_valid  <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_clr_busy <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clr_busy) begin
                if (r_clr_addr == LAST_C) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + HIST_AW'(1);
            end
            r_b_valid  <= i_ctrl.req & i_ctrl.bump;
            r_fw_valid <= r_b_valid;
        end
        r_b_addr  <= idx;
        r_fw_addr <= r_b_addr;
        r_fw_data <= new_val;
    end

    assign o_busy    = r_clr_busy | r_b_valid;
    assign o_rd_data = ram_q;

endmodule

// File: hdl/two_locus_pair_histogram_core.sv
// Two-locus pair histogram: control sequencer, site store and pair scan pipeline.
// Depends on tlph_pkg, tlph_ram and tlph_hist.
//
// Input channel (i_valid/o_ready) takes one operation per transfer: clear, add site,
// read cell, or no-op. Output channel (o_valid/i_ready) returns one result per
// operation: pair_count and status. Configuration writes (i_cfg_wr_en) land at once.
// One operation is processed at a time; a finished result sits in the output
// register so the next operation is taken while it waits.
// Steps per operation, as run by the sequencer through the single site-store read port:
//   add site : one stored site read per cycle, then a pipeline drain that lasts longer
//              when the last pairs match; the first site is stored without a scan
//   reject or store full: straight to the result
//   clear    : one histogram entry zeroed per cycle
//   read     : request state, then data state
// After reset the histogram is swept to zero with o_ready low; configuration writes are
// still taken. When the receiver stalls, the result holds and the block holds after
// its next operation finishes until the output register frees.
module two_locus_pair_histogram_core #(
    parameter int MAX_SAMPLES = tlph_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_SITES   = tlph_pkg::MAX_SITES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [tlph_pkg::OP_W-1:0]          i_operation,
    input  logic [tlph_pkg::SITE_W-1:0]        i_site_bits,
    input  logic [tlph_pkg::ROWCOL_W-1:0]      i_row_size,
    input  logic [tlph_pkg::ROWCOL_W-1:0]      i_col_size,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [tlph_pkg::CELL_W-1:0]        o_pair_count,
    output logic [tlph_pkg::STATUS_W-1:0]      o_status,
    input  logic                               i_cfg_wr_en,
    input  logic [tlph_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [tlph_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CNT_W    = $clog2(MAX_SAMPLES);
    localparam int POP_W    = $clog2(MAX_SAMPLES + 1);
    localparam int SITE_AW  = $clog2(MAX_SITES);
    localparam int STORE_W  = MAX_SAMPLES + CNT_W;
    localparam int HIST_DIM = MAX_SAMPLES - 1;
    localparam int CELL_W   = tlph_pkg::CELL_W;
    localparam int SCOUNT_W = tlph_pkg::SCOUNT_W;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_COUNT  = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_DRAIN  = 8'b0000_1000,
        S_CLEAR  = 8'b0001_0000,
        S_RDREQ  = 8'b0010_0000,
        S_RDDATA = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state                       r_state, n_state;
    logic [tlph_pkg::REL_W-1:0]   r_relation;
    logic [SCOUNT_W-1:0]          r_sample_count;
    logic [SITE_AW:0]             r_stored, n_stored;
    logic [SITE_AW:0]             r_scan_end, n_scan_end;
    logic [SITE_AW-1:0]           r_scan_addr, n_scan_addr;
    logic [MAX_SAMPLES-1:0]       r_site, n_site;
    logic [MAX_SAMPLES-1:0]       r_mask, n_mask;
    logic [POP_W-1:0]             r_n, n_n;
    logic [POP_W-1:0]             r_k, n_k;
    logic                         r_rd_ok, n_rd_ok;
    logic [CELL_W-1:0]            r_res_count, n_res_count;
    logic [tlph_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic                         r_o_valid, n_o_valid;
    logic [CELL_W-1:0]            r_o_count, n_o_count;
    logic [tlph_pkg::STATUS_W-1:0] r_o_status, n_o_status;
    logic                         r_s1_valid;
    logic                         r_bump_valid;
    logic [CNT_W-1:0]             r_row, n_row;
    logic [CNT_W-1:0]             r_col, n_col;

    logic [SCOUNT_W-1:0]          n_act7;
    logic [MAX_SAMPLES-1:0]       mask_c;
    logic [tlph_pkg::POP_FULL_W-1:0] pop_full;
    logic [POP_W-1:0]             k_pop;
    logic [CNT_W-1:0]             k_c;
    logic                         store_we;
    logic                         store_re;
    logic [STORE_W-1:0]           store_q;
    logic [MAX_SAMPLES-1:0]       old_bits;
    logic [CNT_W-1:0]             old_k;
    logic [MAX_SAMPLES-1:0]       both;
    logic                         match;
    logic                         hist_busy;
    logic [CELL_W-1:0]            hist_q;
    tlph_pkg::t_hist_ctrl         hist_ctrl;
    logic                         rd_in_range;
    logic [CNT_W-1:0]             rd_r;
    logic [CNT_W-1:0]             rd_c;
    logic                         clear_go;

    // active sample count and mask from the current register value
    always_comb begin
        if (r_sample_count < SCOUNT_W'(2)) begin
            n_act7 = SCOUNT_W'(2);
        end else if (r_sample_count > SCOUNT_W'(MAX_SAMPLES)) begin
            n_act7 = SCOUNT_W'(MAX_SAMPLES);
        end else begin
            n_act7 = r_sample_count;
        end
        for (int i = 0; i < MAX_SAMPLES; i++) begin
            mask_c[i] = (SCOUNT_W'(i) < n_act7);
        end
    end

    assign pop_full = tlph_pkg::popcount(tlph_pkg::SITE_W'(r_site));
    assign k_pop    = pop_full[POP_W-1:0];
    assign k_c      = r_k[CNT_W-1:0];

    assign rd_in_range = (i_row_size != '0) && (i_col_size != '0)
                      && (i_row_size <= tlph_pkg::ROWCOL_W'(HIST_DIM))
                      && (i_col_size <= tlph_pkg::ROWCOL_W'(HIST_DIM));
    assign rd_r = i_row_size[CNT_W-1:0];
    assign rd_c = i_col_size[CNT_W-1:0];

    // site store: masked bits with derived count on top
    assign store_re = (r_state == S_SCAN);

    tlph_ram #(
        .WIDTH (STORE_W),
        .DEPTH (MAX_SITES)
    ) u_site_ram (
        .i_clk     (i_clk),
        .i_wr_en   (store_we),
        .i_wr_addr (r_stored[SITE_AW-1:0]),
        .i_wr_data ({k_pop[CNT_W-1:0], r_site}),
        .i_rd_en   (store_re),
        .i_rd_addr (r_scan_addr),
        .o_rd_data (store_q)
    );

    assign old_bits = store_q[MAX_SAMPLES-1:0] & r_mask;
    assign old_k    = store_q[STORE_W-1:MAX_SAMPLES];
    assign both     = r_site & old_bits;

    always_comb begin
        case (tlph_pkg::t_relation'(r_relation))
            tlph_pkg::REL_ANY:      match = 1'b1;
            tlph_pkg::REL_NESTED:   match = (|both)
                                          && !((|(r_site & ~old_bits)) && (|(old_bits & ~r_site)));
            tlph_pkg::REL_DISJOINT: match = ~(|both);
            default:                match = 1'b0;
        endcase
    end

    assign hist_ctrl.req   = r_bump_valid | ((r_state == S_RDREQ) & r_rd_ok);
    assign hist_ctrl.bump  = r_bump_valid;
    assign hist_ctrl.clear = clear_go;

    tlph_hist #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (hist_ctrl),
        .i_row     (r_row),
        .i_col     (r_col),
        .o_busy    (hist_busy),
        .o_rd_data (hist_q)
    );

    assign o_ready = (r_state == S_IDLE) && !hist_busy;

    always_comb begin
        n_state      = r_state;
        n_stored     = r_stored;
        n_scan_end   = r_scan_end;
        n_scan_addr  = r_scan_addr;
        n_site       = r_site;
        n_mask       = r_mask;
        n_n          = r_n;
        n_k          = r_k;
        n_rd_ok      = r_rd_ok;
        n_res_count  = r_res_count;
        n_res_status = r_res_status;
        n_o_valid    = r_o_valid;
        n_o_count    = r_o_count;
        n_o_status   = r_o_status;
        n_row        = r_row;
        n_col        = r_col;
        store_we     = 1'b0;
        clear_go     = 1'b0;

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        // pair stage: canonical cell is (min, max) of the two counts
        if (r_s1_valid) begin
            n_row = (k_c < old_k) ? k_c : old_k;
            n_col = (k_c < old_k) ? old_k : k_c;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_res_count  = '0;
                    n_res_status = tlph_pkg::ST_OK;
                    case (tlph_pkg::t_op'(i_operation))
                        tlph_pkg::OP_CLEAR: begin
                            n_stored = '0;
                            clear_go = 1'b1;
                            n_state  = S_CLEAR;
                        end
                        tlph_pkg::OP_ADD: begin
                            n_site  = i_site_bits[MAX_SAMPLES-1:0] & mask_c;
                            n_mask  = mask_c;
                            n_n     = n_act7[POP_W-1:0];
                            n_state = S_COUNT;
                        end
                        tlph_pkg::OP_READ: begin
                            n_rd_ok = rd_in_range;
                            n_row   = (rd_r < rd_c) ? rd_r : rd_c;
                            n_col   = (rd_r < rd_c) ? rd_c : rd_r;
                            n_state = S_RDREQ;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_COUNT: begin
                n_k = k_pop;
                if ((k_pop == '0) || (k_pop >= r_n)) begin
                    n_res_status = tlph_pkg::ST_REJECT;
                    n_state      = S_DONE;
                end else if (r_stored >= (SITE_AW + 1)'(MAX_SITES)) begin
                    n_res_status = tlph_pkg::ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    store_we    = 1'b1;
                    n_scan_end  = r_stored;
                    n_stored    = r_stored + (SITE_AW + 1)'(1);
                    n_scan_addr = '0;
                    n_state     = (r_stored == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                n_scan_addr = r_scan_addr + SITE_AW'(1);
                if (((SITE_AW + 1)'(r_scan_addr) + (SITE_AW + 1)'(1)) == r_scan_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_s1_valid && !r_bump_valid && !hist_busy) begin
                    n_state = S_DONE;
                end
            end
            S_CLEAR: begin
                if (!hist_busy) begin
                    n_state = S_DONE;
                end
            end
            S_RDREQ: begin
                n_state = S_RDDATA;
            end
            S_RDDATA: begin
                n_res_count = r_rd_ok ? hist_q : '0;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_count  = r_res_count;
                    n_o_status = r_res_status;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_relation     <= tlph_pkg::REL_ANY;
            r_sample_count <= tlph_pkg::SAMPLE_COUNT_RESET;
            r_stored       <= '0;
            r_o_valid      <= 1'b0;
            r_s1_valid     <= 1'b0;
            r_bump_valid   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_stored     <= n_stored;
            r_o_valid    <= n_o_valid;
            r_s1_valid   <= store_re;
            r_bump_valid <= r_s1_valid & match;
            if (i_cfg_wr_en) begin
                case (tlph_pkg::t_cfg_index'(i_cfg_index))
                    tlph_pkg::CFG_RELATION: r_relation     <= i_cfg_data[tlph_pkg::REL_W-1:0];
                    tlph_pkg::CFG_SAMPLES:  r_sample_count <= i_cfg_data[SCOUNT_W-1:0];
                    default: ;
                endcase
            end
        end
        r_scan_end   <= n_scan_end;
        r_scan_addr  <= n_scan_addr;
        r_site       <= n_site;
        r_mask       <= n_mask;
        r_n          <= n_n;
        r_k          <= n_k;
        r_rd_ok      <= n_rd_ok;
        r_res_count  <= n_res_count;
        r_res_status <= n_res_status;
        r_o_count    <= n_o_count;
        r_o_status   <= n_o_status;
        r_row        <= n_row;
        r_col        <= n_col;
    end

    assign o_valid      = r_o_valid;
    assign o_pair_count = r_o_count;
    assign o_status     = r_o_status;

endmodule
